// File: rtl/capacity_fair_share_allocator_core_assert.svh
// Assertion macros used by the checker file.
`ifndef CAPACITY_FAIR_SHARE_ALLOCATOR_CORE_ASSERT_SVH
`define CAPACITY_FAIR_SHARE_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CFSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cfsa_pkg.sv
package cfsa_pkg;

  localparam int MAX_BINS = 16;
  localparam int IDX_W    = $clog2(MAX_BINS);
  localparam int CNT_W    = $clog2(MAX_BINS + 1);
  localparam int CAP_W    = 10;
  localparam int DEM_W    = 16;
  localparam int MODE_W   = 2;
  localparam int RANK_W   = 4;
  localparam int DIV_CNT_W = $clog2(DEM_W);

  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD       = 2'd0,
    MODE_DISTRIBUTE = 2'd1,
    MODE_CLEAR      = 2'd2,
    MODE_NONE       = 2'd3
  } mode_t;

  localparam logic POLICY_FAIR   = 1'b0;
  localparam logic POLICY_FEWEST = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_INSERT   = 6'b000010,
    ST_FAIR_DIV = 6'b000100,
    ST_FAIR_UPD = 6'b001000,
    ST_FEWEST   = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_t;

endpackage

// File: rtl/capacity_fair_share_allocator_core.sv
// Load: insertion walks down the table one entry per cycle until it finds its place.
// Distribute, policy 0: the 16-step shared restoring divider plus one update per bin;
// policy 1: one update per bin. Both then give one result per cycle while m_tready is high.
// Clear/ignored items stay in idle. s_tready is high only while the sequencer is idle.
// rst is synchronous and active high; it clears the table count, policy and output valid.
module capacity_fair_share_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // capacity [9:0], demand [25:10], zero pad [31:26]
  input  logic [cfsa_pkg::S_DATA_W-1:0] s_tdata,
  // mode [1:0]
  input  logic [cfsa_pkg::MODE_W-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // bin_rank [3:0], bin_capacity [13:4], assigned [23:14], unplaced [39:24]
  output logic [cfsa_pkg::M_DATA_W-1:0] m_tdata,
  output logic                          m_tlast
);

  cfsa_pkg::state_t state;

  logic                         policy;
  logic [cfsa_pkg::CNT_W-1:0]   bin_count;
  logic [cfsa_pkg::DEM_W-1:0]   rem;
  logic [cfsa_pkg::IDX_W-1:0]   idx;
  logic [cfsa_pkg::CNT_W-1:0]   ins_k;
  logic [cfsa_pkg::CAP_W-1:0]   ins_cap;

  // Shared restoring divider: dividend/quotient shift register and partial remainder.
  logic [cfsa_pkg::DEM_W-1:0]     div_q;
  logic [cfsa_pkg::IDX_W-1:0]     div_r;
  logic [cfsa_pkg::DIV_CNT_W-1:0] div_step;

  logic [cfsa_pkg::CAP_W-1:0] caps [cfsa_pkg::MAX_BINS];
  logic [cfsa_pkg::CAP_W-1:0] asg  [cfsa_pkg::MAX_BINS];

  logic [cfsa_pkg::MODE_W-1:0]  in_mode;
  logic [cfsa_pkg::CAP_W-1:0]   in_cap;
  logic [cfsa_pkg::DEM_W-1:0]   in_dem;
  logic                         in_fire;

  logic [cfsa_pkg::IDX_W-1:0]   rd_addr;
  logic [cfsa_pkg::CAP_W-1:0]   rd_cap;
  logic                         ins_shift;

  logic [cfsa_pkg::IDX_W:0]     div_d;
  logic [cfsa_pkg::IDX_W:0]     div_t;
  logic                         div_ge;

  logic [cfsa_pkg::CAP_W-1:0]   asg_next;
  logic [cfsa_pkg::DEM_W-1:0]   rem_next;
  logic                         asg_we;

  logic                         out_load;
  logic                         emit_empty;
  logic                         emit_fin;

  assign in_mode = s_tuser;
  assign in_cap  = s_tdata[cfsa_pkg::CAP_W-1:0];
  assign in_dem  = s_tdata[cfsa_pkg::CAP_W +: cfsa_pkg::DEM_W];

  assign s_tready = (state == cfsa_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  // One read port on the capacity table, shared by insertion, fill and output.
  logic [cfsa_pkg::CNT_W-1:0] ins_km1;
  assign ins_km1 = ins_k - cfsa_pkg::CNT_W'(1);
  assign rd_addr = (state == cfsa_pkg::ST_INSERT) ? ins_km1[cfsa_pkg::IDX_W-1:0] : idx;
  assign rd_cap  = caps[rd_addr];

  // Keep moving entries up while the one below is strictly smaller.
  assign ins_shift = (ins_k != '0) && (rd_cap < ins_cap);

  assign div_d  = {1'b0, idx} + (cfsa_pkg::IDX_W + 1)'(1);
  assign div_t  = {div_r, div_q[cfsa_pkg::DEM_W-1]};
  assign div_ge = (div_t >= div_d);

  always_comb begin
    asg_next = '0;
    rem_next = rem;
    asg_we   = 1'b0;
    case (state)
      cfsa_pkg::ST_FAIR_UPD: begin
        asg_we = 1'b1;
        if (div_q > {{(cfsa_pkg::DEM_W - cfsa_pkg::CAP_W){1'b0}}, rd_cap}) begin
          asg_next = rd_cap;
        end else begin
          asg_next = div_q[cfsa_pkg::CAP_W-1:0];
        end
        rem_next = rem - {{(cfsa_pkg::DEM_W - cfsa_pkg::CAP_W){1'b0}}, asg_next};
      end
      cfsa_pkg::ST_FEWEST: begin
        asg_we = 1'b1;
        if (rem > {{(cfsa_pkg::DEM_W - cfsa_pkg::CAP_W){1'b0}}, rd_cap}) begin
          asg_next = rd_cap;
          rem_next = rem - {{(cfsa_pkg::DEM_W - cfsa_pkg::CAP_W){1'b0}}, rd_cap};
        end else begin
          asg_next = rem[cfsa_pkg::CAP_W-1:0];
          rem_next = '0;
        end
      end
      default: begin
        asg_we = 1'b0;
      end
    endcase
  end

  assign out_load   = (state == cfsa_pkg::ST_EMIT) && (!m_tvalid || m_tready);
  assign emit_empty = (bin_count == '0);
  assign emit_fin   = emit_empty || ({1'b0, idx} + cfsa_pkg::CNT_W'(1) == bin_count);

  // Table storage has no reset; only entries below bin_count are ever used.
  always_ff @(posedge clk) begin
    if (state == cfsa_pkg::ST_INSERT) begin
      caps[ins_k[cfsa_pkg::IDX_W-1:0]] <= ins_shift ? rd_cap : ins_cap;
    end
    if (asg_we) begin
      asg[idx] <= asg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[cfsa_pkg::RANK_W-1:0] <= cfsa_pkg::RANK_W'(idx);
      m_tdata[cfsa_pkg::RANK_W +: cfsa_pkg::CAP_W] <= emit_empty ? '0 : rd_cap;
      m_tdata[cfsa_pkg::RANK_W + cfsa_pkg::CAP_W +: cfsa_pkg::CAP_W] <=
        emit_empty ? '0 : asg[idx];
      m_tdata[cfsa_pkg::RANK_W + 2*cfsa_pkg::CAP_W +: cfsa_pkg::DEM_W] <=
        emit_fin ? rem : '0;
      m_tlast <= emit_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cfsa_pkg::ST_IDLE;
      policy    <= cfsa_pkg::POLICY_FAIR;
      bin_count <= '0;
      rem       <= '0;
      idx       <= '0;
      ins_k     <= '0;
      ins_cap   <= '0;
      div_q     <= '0;
      div_r     <= '0;
      div_step  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy <= cfg_wdata;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        cfsa_pkg::ST_IDLE: begin
          if (in_fire) begin
            case (in_mode)
              cfsa_pkg::MODE_LOAD: begin
                if (bin_count < cfsa_pkg::CNT_W'(cfsa_pkg::MAX_BINS)) begin
                  ins_k   <= bin_count;
                  ins_cap <= in_cap;
                  state   <= cfsa_pkg::ST_INSERT;
                end
              end
              cfsa_pkg::MODE_DISTRIBUTE: begin
                rem <= in_dem;
                if (bin_count == '0) begin
                  idx   <= '0;
                  state <= cfsa_pkg::ST_EMIT;
                end else if (policy == cfsa_pkg::POLICY_FAIR) begin
                  idx      <= cfsa_pkg::IDX_W'(bin_count - cfsa_pkg::CNT_W'(1));
                  div_q    <= in_dem;
                  div_r    <= '0;
                  div_step <= '0;
                  state    <= cfsa_pkg::ST_FAIR_DIV;
                end else begin
                  idx   <= '0;
                  state <= cfsa_pkg::ST_FEWEST;
                end
              end
              cfsa_pkg::MODE_CLEAR: begin
                bin_count <= '0;
              end
              default: begin
                state <= cfsa_pkg::ST_IDLE;
              end
            endcase
          end
        end
        cfsa_pkg::ST_INSERT: begin
          if (ins_shift) begin
            ins_k <= ins_km1;
          end else begin
            bin_count <= bin_count + cfsa_pkg::CNT_W'(1);
            state     <= cfsa_pkg::ST_IDLE;
          end
        end
        cfsa_pkg::ST_FAIR_DIV: begin
          div_q <= {div_q[cfsa_pkg::DEM_W-2:0], div_ge};
          if (div_ge) begin
            div_r <= cfsa_pkg::IDX_W'(div_t - div_d);
          end else begin
            div_r <= cfsa_pkg::IDX_W'(div_t);
          end
          div_step <= div_step + cfsa_pkg::DIV_CNT_W'(1);
          if (div_step == cfsa_pkg::DIV_CNT_W'(cfsa_pkg::DEM_W - 1)) begin
            state <= cfsa_pkg::ST_FAIR_UPD;
          end
        end
        cfsa_pkg::ST_FAIR_UPD: begin
          rem <= rem_next;
          if (idx == '0) begin
            state <= cfsa_pkg::ST_EMIT;
          end else begin
            idx      <= idx - cfsa_pkg::IDX_W'(1);
            div_q    <= rem_next;
            div_r    <= '0;
            div_step <= '0;
            state    <= cfsa_pkg::ST_FAIR_DIV;
          end
        end
        cfsa_pkg::ST_FEWEST: begin
          rem <= rem_next;
          if ({1'b0, idx} + cfsa_pkg::CNT_W'(1) == bin_count) begin
            idx   <= '0;
            state <= cfsa_pkg::ST_EMIT;
          end else begin
            idx <= idx + cfsa_pkg::IDX_W'(1);
          end
        end
        cfsa_pkg::ST_EMIT: begin
          if (out_load) begin
            if (emit_fin) begin
              state <= cfsa_pkg::ST_IDLE;
            end else begin
              idx <= idx + cfsa_pkg::IDX_W'(1);
            end
          end
        end
        default: begin
          state <= cfsa_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/cfsa_checker.sv
`include "capacity_fair_share_allocator_core_assert.svh"

module cfsa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [cfsa_pkg::M_DATA_W-1:0] m_tdata,
  input logic                          m_tlast
);

  logic [cfsa_pkg::CAP_W-1:0]  chk_cap;
  logic [cfsa_pkg::CAP_W-1:0]  chk_asg;
  logic [cfsa_pkg::DEM_W-1:0]  chk_unplaced;
  logic [cfsa_pkg::M_DATA_W:0] out_word;
  logic                        out_stall;
  logic                        mid_run;

  assign chk_cap      = m_tdata[cfsa_pkg::RANK_W +: cfsa_pkg::CAP_W];
  assign chk_asg      = m_tdata[cfsa_pkg::RANK_W + cfsa_pkg::CAP_W +: cfsa_pkg::CAP_W];
  assign chk_unplaced = m_tdata[cfsa_pkg::RANK_W + 2*cfsa_pkg::CAP_W +: cfsa_pkg::DEM_W];
  assign out_word     = {m_tlast, m_tdata};
  assign out_stall    = m_tvalid && !m_tready;
  assign mid_run      = m_tvalid && !m_tlast;

  // A stalled result must not change under the consumer.
  `CFSA_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "stalled result moved")

  // A bin never receives more than its capacity.
  `CFSA_ASSERT_NOW(a_asg_le_cap, m_tvalid, chk_asg <= chk_cap, "assigned exceeds bin capacity")

  // The shortfall only appears on the final result of a run.
  `CFSA_ASSERT_NOW(a_unplaced_last, mid_run, chk_unplaced == '0, "shortfall before last")

  // No new item is taken while a run still has results to send.
  `CFSA_ASSERT_NOW(a_busy_mid_run, mid_run, !(s_tvalid && s_tready), "item taken mid-run")

endmodule

bind capacity_fair_share_allocator_core cfsa_checker u_cfsa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // One bin result as it leaves the block: {m_tlast, m_tdata}.
  typedef struct packed {
    logic        last;
    logic [15:0] unplaced;
    logic [9:0]  assigned;
    logic [9:0]  bin_cap;
    logic [3:0]  rank;
  } alloc_t;

  typedef struct packed {
    logic            wr_policy;
    logic            policy;
    cfsa_pkg::mode_t mode;
    logic [9:0]      cap;
    logic [15:0]     dem;
    logic            typed;
    alloc_t          exp_res;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic                          cfg_wdata = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [cfsa_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic [cfsa_pkg::MODE_W-1:0]   s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [cfsa_pkg::M_DATA_W-1:0] m_tdata;
  logic                          m_tlast;

  // Shadow copy of the bin table and the policy register.
  logic [9:0]  bin_tbl [cfsa_pkg::MAX_BINS];
  int unsigned bin_cnt;
  logic        cur_policy;
  alloc_t      alloc_q [$];

  dir_row_t    dir_tab [$];
  int unsigned err_cnt, got_results, cyc, hold_left;
  int unsigned n_items, n_dist, n_load, n_clear, n_ignored, n_full, n_pol_writes;
  bit          held_once;
  logic [9:0]  last_cap = '0;
  logic        quiet;

  always #5 clk = ~clk;

  capacity_fair_share_allocator_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always @(posedge clk) cyc <= cyc + 1;

  // Neither side adds random gaps inside this window.
  assign quiet = (cyc >= 1500) && (cyc < 4500);

  // Advances the shadow table by one accepted item and queues the bin results.
  function automatic void allocate_item(input cfsa_pkg::mode_t m, input logic [9:0] c,
                                        input logic [15:0] d, input logic typed,
                                        input alloc_t typed_res);
    int unsigned rem, share, pos, k;
    logic [9:0]  asg [cfsa_pkg::MAX_BINS];
    alloc_t      r;
    case (m)
      cfsa_pkg::MODE_LOAD: begin
        if (bin_cnt < cfsa_pkg::MAX_BINS) begin
          pos = 0;
          // Equal capacities keep their arrival order.
          while (pos < bin_cnt && bin_tbl[pos] >= c) pos++;
          for (k = bin_cnt; k > pos; k--) bin_tbl[k] = bin_tbl[k-1];
          bin_tbl[pos] = c;
          bin_cnt++;
        end
      end
      cfsa_pkg::MODE_CLEAR: bin_cnt = 0;
      cfsa_pkg::MODE_DISTRIBUTE: begin
        rem = d;
        if (typed) begin
          alloc_q.push_back(typed_res);
        end else if (bin_cnt == 0) begin
          r = '0;
          r.last = 1'b1;
          r.unplaced = d;
          alloc_q.push_back(r);
        end else begin
          if (cur_policy == cfsa_pkg::POLICY_FAIR) begin
            // Water filling from the smallest bin upward.
            for (k = bin_cnt; k > 0; k--) begin
              share = rem / k;
              asg[k-1] = (share > bin_tbl[k-1]) ? bin_tbl[k-1] : 10'(share);
              rem -= asg[k-1];
            end
          end else begin
            for (k = 0; k < bin_cnt; k++) begin
              if (rem > bin_tbl[k]) begin
                asg[k] = bin_tbl[k];
                rem -= bin_tbl[k];
              end else begin
                asg[k] = 10'(rem);
                rem = 0;
              end
            end
          end
          for (k = 0; k < bin_cnt; k++) begin
            r.rank = 4'(k);
            r.bin_cap = bin_tbl[k];
            r.assigned = asg[k];
            r.last = (k + 1 == bin_cnt);
            r.unplaced = r.last ? 16'(rem) : 16'd0;
            alloc_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic add_row(input logic wr, input logic pol, input cfsa_pkg::mode_t m,
                         input logic [9:0] c, input logic [15:0] d,
                         input logic typed, input alloc_t er);
    dir_row_t row;
    row.wr_policy = wr;
    row.policy = pol;
    row.mode = m;
    row.cap = c;
    row.dem = d;
    row.typed = typed;
    row.exp_res = er;
    dir_tab.push_back(row);
  endtask

  task automatic offer_item(input cfsa_pkg::mode_t m, input logic [9:0] c,
                            input logic [15:0] d,
                            input logic typed = 1'b0, input alloc_t typed_res = '0);
    if (!quiet && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(99) < 20);
    end
    s_tvalid <= 1'b1;
    s_tuser <= m;
    s_tdata <= {6'b0, d, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (m == cfsa_pkg::MODE_NONE ||
        (m == cfsa_pkg::MODE_LOAD && bin_cnt >= cfsa_pkg::MAX_BINS)) begin
      n_ignored++;
    end else begin
      n_items++;
      if (m == cfsa_pkg::MODE_LOAD) n_load++;
      if (m == cfsa_pkg::MODE_CLEAR) n_clear++;
      if (m == cfsa_pkg::MODE_DISTRIBUTE) begin
        n_dist++;
        if (bin_cnt == cfsa_pkg::MAX_BINS) n_full++;
      end
    end
    allocate_item(m, c, d, typed, typed_res);
  endtask

  // The block must be idle for a register write; loads give no result, so
  // some extra cycles cover an insertion still walking the table.
  task automatic write_policy(input logic p);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (alloc_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_policy = p;
    n_pol_writes++;
  endtask

  // Receiver: random back-pressure plus one long hold-off, started while a result
  // waits and the sender is offering, so the input can stall.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      held_once <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_once && got_results >= 150 && s_tvalid && m_tvalid) begin
      m_tready <= 1'b0;
      hold_left <= 800;
      held_once <= 1'b1;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin
    alloc_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata};
      got_results <= got_results + 1;
      if (alloc_q.size() == 0) begin
        $display("%0t: unexpected result rank %0d cap %0d assigned %0d unplaced %0d last %0d",
                 $time, got.rank, got.bin_cap, got.assigned, got.unplaced, got.last);
        err_cnt++;
      end else begin
        want = alloc_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected rank %0d cap %0d assigned %0d unplaced %0d last %0d",
                   $time, want.rank, want.bin_cap, want.assigned, want.unplaced, want.last);
          $display("%0t:          actual   rank %0d cap %0d assigned %0d unplaced %0d last %0d",
                   $time, got.rank, got.bin_cap, got.assigned, got.unplaced, got.last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned n, extra, n_runs, sum, pre, i, j;
    logic [9:0]  c;
    logic [15:0] d;

    add_row(1'b1, cfsa_pkg::POLICY_FAIR, cfsa_pkg::MODE_NONE, 10'd0, 16'd0, 1'b0, '0);
    // An empty table returns one closing result holding the whole demand.
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'd0, 1'b1,
            {1'b1, 16'd0, 10'd0, 10'd0, 4'd0});
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'h3FF, 16'hFFFF, 1'b1,
            {1'b1, 16'hFFFF, 10'd0, 10'd0, 4'd0});
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_NONE, 10'h3FF, 16'hFFFF, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_LOAD, 10'h3FF, 16'hFFFF, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'hFFFF, 1'b1,
            {1'b1, 16'd64512, 10'd1023, 10'd1023, 4'd0});
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_LOAD, 10'd0, 16'd0, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_LOAD, 10'h3FF, 16'd0, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_LOAD, 10'd300, 16'd0, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_LOAD, 10'd300, 16'd0, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'd1000, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'hFFFF, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'd0, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'd3, 1'b0, '0);
    add_row(1'b1, cfsa_pkg::POLICY_FEWEST, cfsa_pkg::MODE_NONE, 10'd0, 16'd0, 1'b0, '0);
    // The remainder lands exactly on a bin's capacity in the next three.
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'd2046, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'd2646, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'd1023, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'd2647, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'd0, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_CLEAR, 10'h3FF, 16'hFFFF, 1'b0, '0);
    add_row(1'b0, 1'b0, cfsa_pkg::MODE_DISTRIBUTE, 10'd0, 16'd5, 1'b1,
            {1'b1, 16'd5, 10'd0, 10'd0, 4'd0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].wr_policy)
        write_policy(dir_tab[r].policy);
      else
        offer_item(dir_tab[r].mode, dir_tab[r].cap, dir_tab[r].dem,
                   dir_tab[r].typed, dir_tab[r].exp_res);
    end

    // Random part: each phase picks a policy, builds a fresh table and then
    // runs several distributions against it, with some noise mixed in.
    while (n_items < 450) begin
      write_policy(1'($urandom_range(1)));
      offer_item(cfsa_pkg::MODE_CLEAR, 10'($urandom), 16'($urandom));
      case ($urandom_range(9))
        0:       n = 0;
        7:       n = $urandom_range(6, 15);
        8, 9:    n = cfsa_pkg::MAX_BINS;
        default: n = $urandom_range(1, 5);
      endcase
      extra = (n == cfsa_pkg::MAX_BINS) ? $urandom_range(2) : 0;
      for (i = 0; i < n + extra; i++) begin
        case ($urandom_range(7))
          0:       c = '0;
          1:       c = 10'h3FF;
          2:       c = last_cap;
          3:       c = 10'($urandom_range(1, 31));
          default: c = 10'($urandom);
        endcase
        last_cap = c;
        offer_item(cfsa_pkg::MODE_LOAD, c, 16'($urandom));
      end
      n_runs = $urandom_range(2, 6);
      for (i = 0; i < n_runs; i++) begin
        if ($urandom_range(9) == 0)
          offer_item(cfsa_pkg::MODE_NONE, 10'($urandom), 16'($urandom));
        if ($urandom_range(14) == 0) begin
          offer_item(cfsa_pkg::MODE_CLEAR, 10'($urandom), 16'($urandom));
          for (j = $urandom_range(2); j > 0; j--)
            offer_item(cfsa_pkg::MODE_LOAD, 10'($urandom), 16'($urandom));
        end
        sum = 0;
        for (j = 0; j < bin_cnt; j++) sum += bin_tbl[j];
        case ($urandom_range(9))
          0: d = '0;
          1: d = 16'hFFFF;
          2: d = 16'(sum);
          3: d = 16'(sum + $urandom_range(3));
          4: d = (sum > 3) ? 16'(sum - $urandom_range(3)) : 16'd0;
          5, 6: d = 16'($urandom_range(sum));
          8: begin
            pre = 0;
            for (j = $urandom_range(bin_cnt); j > 0; j--) pre += bin_tbl[j-1];
            d = 16'(pre);
          end
          default: d = 16'($urandom);
        endcase
        offer_item(cfsa_pkg::MODE_DISTRIBUTE, 10'($urandom), d);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (alloc_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d items (%0d loads, %0d distributions, %0d clears) and %0d ignored ones.",
             n_items, n_load, n_dist, n_clear, n_ignored);
    $display("Checked %0d bin results across %0d policy writes; %0d runs used a full table.",
             got_results, n_pol_writes, n_full);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
